FILE: rtl/b2da_pkg.sv
// Shared constants and types of the binary to decimal ASCII emitter.
package b2da_pkg;

    localparam int NUM_WIDTH   = 32;
    // Decimal digits needed for NUM_WIDTH bits: floor(NUM_WIDTH * log10(2)) + 1
    localparam int NUM_DIGITS  = (NUM_WIDTH * 30103) / 100000 + 1;
    localparam int BIT_CNT_W   = $clog2(NUM_WIDTH);
    localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);
    localparam int CHAR_W      = 6;
    localparam int BCD_W       = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
    localparam logic [BCD_W-1:0]  DABBLE_MIN = BCD_W'(5);
    localparam logic [BCD_W-1:0]  DABBLE_ADD = BCD_W'(3);

    // Control broadcast to every cell of the digit chain
    typedef struct packed {
        logic clear;   // zero the digit
        logic dabble;  // add-3 correction then shift one binary bit in
        logic move;    // take the lower neighbor's digit
    } cell_ctrl_t;

endpackage

FILE: rtl/b2da_cell.sv
// One BCD digit cell of the shift-and-add-3 chain.
module b2da_cell (
    input  logic                             clk,
    input  b2da_pkg::cell_ctrl_t             ctrl,
    input  logic                             bit_in,
    input  logic [b2da_pkg::BCD_W-1:0]       digit_in,
    output logic                             bit_out,
    output logic [b2da_pkg::BCD_W-1:0]       digit
);

    logic [b2da_pkg::BCD_W-1:0] digit_reg;
    logic [b2da_pkg::BCD_W-1:0] digit_next;
    logic [b2da_pkg::BCD_W-1:0] adj;

    always_comb
    begin
        if (digit_reg >= b2da_pkg::DABBLE_MIN)
        begin
            adj = digit_reg + b2da_pkg::DABBLE_ADD;
        end
        else
        begin
            adj = digit_reg;
        end
    end

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[b2da_pkg::BCD_W-2:0], bit_in};
        end
        else if (ctrl.move)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign bit_out = adj[b2da_pkg::BCD_W-1];
    assign digit   = digit_reg;

endmodule

FILE: rtl/binary_to_decimal_ascii_emitter_unit.sv
// Top level: sequencer and digit chain of the binary to decimal ASCII emitter.
// The bit-serial shift-and-add-3 chain converts the number in the conversion state, then the
// emit state walks the NUM_DIGITS digits from the top, dropping leading zeros. A new request
// is taken only while idle, after the emit state of the previous request has ended.
// Results leave on strobe, one per cycle; the receiver cannot stall.
// rst_n clears the sequencer and the output strobe asynchronously; digits need no reset.
module binary_to_decimal_ascii_emitter_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [b2da_pkg::NUM_WIDTH-1:0]       number,
    output logic                                 strobe,
    output logic [b2da_pkg::CHAR_W-1:0]          digit_char,
    output logic                                 last_digit
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam int ND = b2da_pkg::NUM_DIGITS;

    logic [1:0]                          state_reg, state_next;
    logic [b2da_pkg::NUM_WIDTH-1:0]      num_reg, num_next;
    logic [b2da_pkg::BIT_CNT_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [b2da_pkg::DIG_CNT_W-1:0]      dig_left_reg, dig_left_next;
    logic                                started_reg, started_next;
    logic                                strobe_reg, strobe_next;
    logic [b2da_pkg::CHAR_W-1:0]         char_reg, char_next;
    logic                                last_reg, last_next;

    logic                                accept;
    logic                                emit_now;
    logic                                final_digit;
    b2da_pkg::cell_ctrl_t                ctrl;

    logic [ND:0]                         carry;
    logic [b2da_pkg::BCD_W-1:0]          digs [ND];
    logic [b2da_pkg::BCD_W-1:0]          top_digit;

    assign accept      = start && (state_reg == ST_IDLE);
    assign top_digit   = digs[ND-1];
    assign final_digit = (dig_left_reg == b2da_pkg::DIG_CNT_W'(1));
    assign emit_now    = (state_reg == ST_EMIT) &&
                         ((top_digit != '0) || started_reg || final_digit);

    assign ctrl.clear  = accept;
    assign ctrl.dabble = (state_reg == ST_CONV);
    assign ctrl.move   = (state_reg == ST_EMIT);

    // Binary bits enter the lowest cell, MSB first
    assign carry[0] = num_reg[b2da_pkg::NUM_WIDTH-1];

    genvar gi;
    generate
        for (gi = 0; gi < ND; gi++)
        begin : g_cell
            logic [b2da_pkg::BCD_W-1:0] lower_digit;
            if (gi == 0)
            begin : g_low
                assign lower_digit = '0;
            end
            else
            begin : g_mid
                assign lower_digit = digs[gi-1];
            end
            b2da_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .bit_in   (carry[gi]),
                .digit_in (lower_digit),
                .bit_out  (carry[gi+1]),
                .digit    (digs[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        num_next      = num_reg;
        bit_cnt_next  = bit_cnt_reg;
        dig_left_next = dig_left_reg;
        started_next  = started_reg;
        strobe_next   = 1'b0;
        char_next     = char_reg;
        last_next     = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    num_next     = number;
                    bit_cnt_next = b2da_pkg::BIT_CNT_W'(b2da_pkg::NUM_WIDTH - 1);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                num_next = {num_reg[b2da_pkg::NUM_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    dig_left_next = b2da_pkg::DIG_CNT_W'(ND);
                    started_next  = 1'b0;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // Drop leading zeros; always emit the units digit
                if (emit_now)
                begin
                    strobe_next  = 1'b1;
                    char_next    = b2da_pkg::ASCII_ZERO +
                                   b2da_pkg::CHAR_W'(top_digit);
                    last_next    = final_digit;
                    started_next = 1'b1;
                end
                dig_left_next = dig_left_reg - 1'b1;
                if (final_digit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        bit_cnt_reg  <= bit_cnt_next;
        dig_left_reg <= dig_left_next;
        started_reg  <= started_next;
        char_reg     <= char_next;
        last_reg     <= last_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign strobe     = strobe_reg;
    assign digit_char = char_reg;
    assign last_digit = last_reg;

`ifndef SYNTHESIS
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (digit_char >= b2da_pkg::ASCII_ZERO) &&
                   (digit_char <= b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(9)))
        else $error("digit_char outside '0'..'9'");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_digit) |=> !strobe)
        else $error("digit emitted right after the last digit");

    a_strobe_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("strobe without a conversion in progress");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !strobe))
        else $error("accepted request did not start a conversion");
`endif

endmodule

FILE: test/tb_binary_to_decimal_ascii_emitter_unit.sv
// Testbench for the binary to decimal ASCII emitter: checks each emitted digit against a predictor.
module tb_binary_to_decimal_ascii_emitter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD   = 8;
    localparam int          RANDOM_ITEMS = 250;
    localparam int          STEADY_ITEMS = 40;
    localparam int          DRAIN_CYCLES = 60;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          MAX_REPORTS  = 10;
    localparam logic [b2da_pkg::NUM_WIDTH-1:0] DEC_BASE = b2da_pkg::NUM_WIDTH'(10);

    typedef struct packed {
        logic [b2da_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } digit_result_t;

    class digit_scoreboard;
        digit_result_t pending[$];
        int unsigned   mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Expand one accepted request into its digit characters, most significant first
        function void note_number(logic [b2da_pkg::NUM_WIDTH-1:0] n);
            logic [b2da_pkg::NUM_WIDTH-1:0] v;
            logic [b2da_pkg::BCD_W-1:0]     digs[$];
            digit_result_t                  r;
            v = n;
            do
            begin
                digs.push_front(b2da_pkg::BCD_W'(v % DEC_BASE));
                v = v / DEC_BASE;
            end
            while (v != 0);
            foreach (digs[i])
            begin
                r.ch   = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(digs[i]);
                r.last = (i == digs.size() - 1);
                pending.push_back(r);
            end
        endfunction

        function void check_result(logic [b2da_pkg::CHAR_W-1:0] ch, logic last);
            digit_result_t exp_r;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected digit: char=%0d last=%0b", ch, last);
                return;
            end
            exp_r = pending.pop_front();
            if (ch !== exp_r.ch || last !== exp_r.last)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("digit mismatch: expected char=%0d last=%0b, got char=%0d last=%0b",
                             exp_r.ch, exp_r.last, ch, last);
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic [b2da_pkg::NUM_WIDTH-1:0] number;
    logic                           strobe;
    logic [b2da_pkg::CHAR_W-1:0]    digit_char;
    logic                           last_digit;

    digit_scoreboard sb = new();
    int unsigned     cycle_count = 0;

    binary_to_decimal_ascii_emitter_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .number     (number),
        .strobe     (strobe),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check_result(digit_char, last_digit);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_binary_to_decimal_ascii_emitter_unit failed");
            $finish;
        end
    end

    // Drop start for a burst of idle cycles, sometimes only once the block has gone idle
    task automatic idle_burst();
        start <= 1'b0;
        if ($urandom_range(0, 1) == 0)
        begin
            while (busy)
                @(posedge clk);
        end
        repeat ($urandom_range(1, 8)) @(posedge clk);
    endtask

    // Hold the request until the block takes it
    task automatic send_number(input logic [b2da_pkg::NUM_WIDTH-1:0] n, input bit allow_idle);
        if (allow_idle && $urandom_range(0, 2) == 0)
            idle_burst();
        start  <= 1'b1;
        number <= n;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_number(n);
    endtask

    function automatic logic [b2da_pkg::NUM_WIDTH-1:0] random_number();
        longint unsigned lo;
        longint unsigned hi;
        int              nd;
        if ($urandom_range(0, 7) == 0)
            return b2da_pkg::NUM_WIDTH'($urandom());
        // Spread over digit counts so short and long runs both occur
        nd = $urandom_range(1, 10);
        lo = 1;
        for (int i = 1; i < nd; i++)
            lo = lo * 10;
        hi = (nd == 10) ? 64'hFFFF_FFFF : lo * 10 - 1;
        if (nd == 1)
            lo = 0;
        return b2da_pkg::NUM_WIDTH'($urandom_range(32'(hi), 32'(lo)));
    endfunction

    initial
    begin
        logic [b2da_pkg::NUM_WIDTH-1:0] directed[$];
        directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101,
                     32'd909, 32'd1000, 32'd65535, 32'd100000, 32'd999999, 32'd1000000,
                     32'd99999999, 32'd999999999, 32'd1000000000, 32'd1000000001,
                     32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE,
                     32'hFFFF_FFFF, 32'd0};
        start  = 1'b0;
        number = '0;
        rst_n  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_number(directed[i], 1'b1);

        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_number(random_number(), i < RANDOM_ITEMS - STEADY_ITEMS);

        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("tb_binary_to_decimal_ascii_emitter_unit passed");
        else
            $display("tb_binary_to_decimal_ascii_emitter_unit failed");
        $finish;
    end

endmodule
